>>> sv/prs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes, scale factors and handshake structs for the rail supervisor.
package prs_pkg;

  localparam int SCANS_AVERAGED_DEF = 10;
  localparam int CHANNELS           = 5;
  localparam int SAMPLE_W           = 12;
  localparam int CH_W               = 3;
  localparam int VAL_W              = 15;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TRIP_W     = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RAIL12_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAIL12_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAIL12_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAIL5_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAIL5_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAIL5_MAX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRIP_CHECKS = 3'd6;

  localparam logic [CFG_DATA_W-1:0] RST_RAIL12_HIGH = 16'd13530;
  localparam logic [CFG_DATA_W-1:0] RST_RAIL12_LOW  = 16'd11070;
  localparam logic [CFG_DATA_W-1:0] RST_RAIL12_MAX  = 16'd3500;
  localparam logic [CFG_DATA_W-1:0] RST_RAIL5_HIGH  = 16'd6600;
  localparam logic [CFG_DATA_W-1:0] RST_RAIL5_LOW   = 16'd4800;
  localparam logic [CFG_DATA_W-1:0] RST_RAIL5_MAX   = 16'd1000;
  localparam logic [TRIP_W-1:0]     RST_TRIP_CHECKS = 4'd3;

  // request codes
  localparam logic REQ_STORE = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  // channel order inside one scan
  localparam logic [CH_W-1:0] CH_V25 = 3'd0;
  localparam logic [CH_W-1:0] CH_V12 = 3'd1;
  localparam logic [CH_W-1:0] CH_V5  = 3'd2;
  localparam logic [CH_W-1:0] CH_I5  = 3'd3;
  localparam logic [CH_W-1:0] CH_I12 = 3'd4;

  // 67925/9216 = (9*7547 + 2) / (9*1024): integer part times 7547, plus floor(2m/9)
  localparam int COEF_W       = 13;
  localparam int PROD_W       = 25;
  localparam int FRAC_W       = 10;
  localparam int FRAC_SHIFT   = 17;
  localparam logic [13:0] FRAC_MUL = 14'd14564;  // ceil(2^17 / 9)

  localparam logic [COEF_W-1:0] COEF_V25 = 13'd7547;
  localparam logic [COEF_W-1:0] COEF_V12 = 13'd3575;
  localparam logic [COEF_W-1:0] COEF_V5  = 13'd715;
  localparam logic [COEF_W-1:0] COEF_I   = 13'd165;

  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] chan;
  } scale_req_t;

  typedef struct packed {
    logic             valid;
    logic [CH_W-1:0]  chan;
    logic [VAL_W-1:0] value;
  } scale_rsp_t;

  function automatic logic [COEF_W-1:0] scale_coef(input logic [CH_W-1:0] chan);
    logic [COEF_W-1:0] c;
    case (chan)
      CH_V25:  c = COEF_V25;
      CH_V12:  c = COEF_V12;
      CH_V5:   c = COEF_V5;
      default: c = COEF_I;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] scale_shift(input logic [CH_W-1:0] chan);
    logic [3:0] s;
    case (chan)
      CH_V25:  s = 4'd10;
      CH_V12:  s = 4'd10;
      CH_V5:   s = 4'd9;
      default: s = 4'd7;
    endcase
    return s;
  endfunction

endpackage

>>> sv/prs_if.sv
`timescale 1ns / 1ps
// Handshake channel interfaces: request, result and register write.
interface prs_req_if;
  import prs_pkg::*;
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, req_type, sample, input ready);
  modport sink (input valid, req_type, sample, output ready);
endinterface

interface prs_res_if;
  logic        valid;
  logic        ready;
  logic [14:0] rail25_mv;
  logic [13:0] rail12_mv;
  logic [12:0] rail5_mv;
  logic [12:0] current5_ma;
  logic [12:0] current12_ma;
  logic        rail12_trip;
  logic        rail5_trip;
  modport source (output valid, rail25_mv, rail12_mv, rail5_mv, current5_ma, current12_ma,
                  rail12_trip, rail5_trip, input ready);
  modport sink (input valid, rail25_mv, rail12_mv, rail5_mv, current5_ma, current12_ma,
                rail12_trip, rail5_trip, output ready);
endinterface

interface prs_cfg_if;
  import prs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/power_rail_supervisor_top.sv
`timescale 1ns / 1ps
// Top level of the two-rail power supervisor: sample store, check sequencer, trip decisions.
// A store word is written into the next slot; stores may arrive back to back while the block is idle.
// A check word walks the store, one memory read per stored sample, then runs the five channel
// sums through the three-stage scaler; no further word is accepted until its result word is
// loaded into the output register, and the walk is set by the single read port of the sample store.
// Reset (rst, synchronous): registers to defaults, store reads as zero through per-entry valid
// bits, write slot and over-current run cleared, no result pending.
module power_rail_supervisor_top #(
  parameter int SCANS_AVERAGED = prs_pkg::SCANS_AVERAGED_DEF
) (
  input logic        clk,
  input logic        rst,
  prs_req_if.sink    req,
  prs_res_if.source  res,
  prs_cfg_if.sink    cfg
);
  import prs_pkg::*;

  localparam int DEPTH  = SCANS_AVERAGED * CHANNELS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = SAMPLE_W + $clog2(SCANS_AVERAGED);
  localparam logic [CH_W-1:0] CH_LAST = CH_I12;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_SCALE  = 2'd2;
  localparam logic [1:0] ST_REPORT = 2'd3;

  // configuration registers
  logic [CFG_DATA_W-1:0] rail12_high_mv, rail12_low_mv, rail12_max_ma;
  logic [CFG_DATA_W-1:0] rail5_high_mv, rail5_low_mv, rail5_max_ma;
  logic [TRIP_W-1:0]     trip_checks;

  // sample store: memory plus per-entry valid bits (unwritten entries read as zero)
  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    vbits;
  logic [ADDR_W-1:0]   slot;
  logic [ADDR_W-1:0]   rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic                rd_vbit;

  logic [1:0]          state;
  logic [CH_W-1:0]     rd_ch;
  logic                rd_pend;
  logic [CH_W-1:0]     rd_pend_ch;
  logic [SUM_W-1:0]    sums [CHANNELS];
  logic [SAMPLE_W-1:0] rd_eff;

  logic                iss_on;
  logic [CH_W-1:0]     iss_ch;
  scale_req_t          sreq;
  scale_rsp_t          srsp;

  // scaled channel values, filled from the scaler
  logic [14:0] v25;
  logic [13:0] v12;
  logic [12:0] v5, i5, i12;
  logic [TRIP_W-1:0] run;

  logic store_fire, check_fire, out_free;
  logic trip12, win5_fault, over5, trip5;
  logic [TRIP_W-1:0] run_inc, run_next;

  assign req.ready  = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign store_fire = req.valid && req.ready && (req.req_type == REQ_STORE);
  assign check_fire = req.valid && req.ready && (req.req_type == REQ_CHECK);
  assign out_free   = !res.valid || res.ready;
  assign rd_eff     = rd_vbit ? rd_data : '0;

  // ---------------- register writes ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rail12_high_mv <= RST_RAIL12_HIGH;
      rail12_low_mv  <= RST_RAIL12_LOW;
      rail12_max_ma  <= RST_RAIL12_MAX;
      rail5_high_mv  <= RST_RAIL5_HIGH;
      rail5_low_mv   <= RST_RAIL5_LOW;
      rail5_max_ma   <= RST_RAIL5_MAX;
      trip_checks    <= RST_TRIP_CHECKS;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_RAIL12_HIGH: rail12_high_mv <= cfg.data;
        REG_RAIL12_LOW:  rail12_low_mv  <= cfg.data;
        REG_RAIL12_MAX:  rail12_max_ma  <= cfg.data;
        REG_RAIL5_HIGH:  rail5_high_mv  <= cfg.data;
        REG_RAIL5_LOW:   rail5_low_mv   <= cfg.data;
        REG_RAIL5_MAX:   rail5_max_ma   <= cfg.data;
        REG_TRIP_CHECKS: trip_checks    <= cfg.data[TRIP_W-1:0];
        default: ;  // unused index, ignored
      endcase
    end
  end

  // ---------------- sample store ----------------
  always_ff @(posedge clk) begin
    if (store_fire) begin
      mem[slot] <= req.sample;
    end
    rd_data <= mem[rd_addr];
    rd_vbit <= vbits[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
      slot  <= '0;
    end else if (store_fire) begin
      vbits[slot] <= 1'b1;
      slot        <= (slot == ADDR_W'(DEPTH - 1)) ? '0 : slot + ADDR_W'(1);
    end
  end

  // ---------------- trip decisions (on the captured scaled values) ----------------
  always_comb begin
    trip12 = ({2'b0, v12} > rail12_high_mv) || ({2'b0, v12} < rail12_low_mv) ||
             ({3'b0, i12} > rail12_max_ma);
    win5_fault = ({3'b0, v5} > rail5_high_mv) || ({3'b0, v5} < rail5_low_mv);
    over5      = ({3'b0, i5} > rail5_max_ma);
    run_inc    = run + TRIP_W'(1);
    trip5      = 1'b0;
    run_next   = '0;
    if (win5_fault) begin
      trip5 = 1'b1;
    end else if (over5) begin
      // run wraps in four bits; a zero trip count trips on every over-current check
      if (run_inc >= trip_checks) begin
        trip5 = 1'b1;
      end else begin
        run_next = run_inc;
      end
    end
  end

  // ---------------- check sequencer ----------------
  // Walk reads every entry in address order; the channel tag rides along with the read.
  // The last read always belongs to the 12 V current channel, so its accumulate lands in
  // the first scale cycle while the 25 V sum, already complete, is issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_pend <= 1'b0;
      iss_on  <= 1'b0;
      run     <= '0;
      res.valid <= 1'b0;
    end else begin
      if (state == ST_REPORT && out_free) begin
        res.valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      rd_pend <= (state == ST_WALK);
      unique case (state)
        ST_IDLE: begin
          if (check_fire) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (rd_addr == ADDR_W'(DEPTH - 1)) begin
            state  <= ST_SCALE;
            iss_on <= 1'b1;
          end
        end
        ST_SCALE: begin
          if (iss_on && iss_ch == CH_LAST) begin
            iss_on <= 1'b0;
          end
          if (srsp.valid && srsp.chan == CH_LAST) begin
            state <= ST_REPORT;
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            run   <= run_next;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // address and channel counters, sums, issue counter
  always_ff @(posedge clk) begin
    rd_pend_ch <= rd_ch;
    if (check_fire) begin
      rd_addr <= '0;
      rd_ch   <= CH_V25;
      sums    <= '{default: '0};
    end else begin
      if (state == ST_WALK) begin
        rd_addr <= (rd_addr == ADDR_W'(DEPTH - 1)) ? '0 : rd_addr + ADDR_W'(1);
        rd_ch   <= (rd_ch == CH_LAST) ? CH_V25 : rd_ch + CH_W'(1);
      end
      if (rd_pend) begin
        sums[rd_pend_ch] <= sums[rd_pend_ch] + SUM_W'(rd_eff);
      end
    end
    if (state == ST_WALK) begin
      iss_ch <= CH_V25;
    end else if (iss_on) begin
      iss_ch <= iss_ch + CH_W'(1);
    end
  end

  // ---------------- scaler ----------------
  assign sreq.valid = iss_on;
  assign sreq.chan  = iss_ch;

  prs_scale #(
    .SCANS_AVERAGED (SCANS_AVERAGED)
  ) u_scale (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .sum (sums[iss_ch]),
    .rsp (srsp)
  );

  always_ff @(posedge clk) begin
    if (srsp.valid) begin
      case (srsp.chan)
        CH_V25:  v25 <= srsp.value;
        CH_V12:  v12 <= srsp.value[13:0];
        CH_V5:   v5  <= srsp.value[12:0];
        CH_I5:   i5  <= srsp.value[12:0];
        default: i12 <= srsp.value[12:0];
      endcase
    end
  end

  // ---------------- result word ----------------
  always_ff @(posedge clk) begin
    if (state == ST_REPORT && out_free) begin
      res.rail25_mv    <= v25;
      res.rail12_mv    <= v12;
      res.rail5_mv     <= v5;
      res.current5_ma  <= i5;
      res.current12_ma <= i12;
      res.rail12_trip  <= trip12;
      res.rail5_trip   <= trip5;
    end
  end

  // ---------------- assertions ----------------
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= ADDR_W'(DEPTH - 1))
    else $error("write slot beyond store depth");

  a_check_starts_walk: assert property (@(posedge clk) disable iff (rst)
    check_fire |=> state == ST_WALK)
    else $error("check word did not start the store walk");

  a_rsp_in_scale: assert property (@(posedge clk) disable iff (rst)
    srsp.valid |-> state == ST_SCALE)
    else $error("scaler response outside the scale phase");

  a_result_from_report: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state) == ST_REPORT)
    else $error("result word raised outside the report step");

endmodule

>>> sv/prs_scale.sv
`timescale 1ns / 1ps
// Three-stage channel scaler: sum to mean, mean times factor, shift to mV or mA.
module prs_scale #(
  parameter int SCANS_AVERAGED = prs_pkg::SCANS_AVERAGED_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  prs_pkg::scale_req_t  req,
  input  logic [prs_pkg::SAMPLE_W+$clog2(SCANS_AVERAGED)-1:0] sum,
  output prs_pkg::scale_rsp_t  rsp
);
  import prs_pkg::*;

  localparam int L      = $clog2(SCANS_AVERAGED);
  localparam int SUM_W  = SAMPLE_W + L;
  localparam int S      = SUM_W + L;
  // reciprocal of the scan count, exact for every sum below 2^SUM_W
  localparam logic [SUM_W:0] MDIV =
    (SUM_W+1)'(((1 << S) + SCANS_AVERAGED - 1) / SCANS_AVERAGED);

  logic [2*SUM_W:0]     div_prod;
  logic                 s1_valid;
  logic [CH_W-1:0]      s1_chan;
  logic [SAMPLE_W-1:0]  s1_mean;
  logic [26:0]          frac_prod;
  logic                 s2_valid;
  logic [CH_W-1:0]      s2_chan;
  logic [PROD_W-1:0]    s2_prod;
  logic [FRAC_W-1:0]    s2_frac;
  logic [PROD_W-1:0]    pre_shift;
  logic [PROD_W-1:0]    shifted;

  assign div_prod  = sum * MDIV;
  assign frac_prod = {s1_mean, 1'b0} * FRAC_MUL;
  assign pre_shift = (s2_chan == CH_V25) ? s2_prod + PROD_W'(s2_frac) : s2_prod;
  assign shifted   = pre_shift >> scale_shift(s2_chan);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      s1_valid  <= req.valid;
      s2_valid  <= s1_valid;
      rsp.valid <= s2_valid;
    end
    s1_chan   <= req.chan;
    s1_mean   <= div_prod[S +: SAMPLE_W];
    s2_chan   <= s1_chan;
    s2_prod   <= PROD_W'(s1_mean) * PROD_W'(scale_coef(s1_chan));
    s2_frac   <= frac_prod[FRAC_SHIFT +: FRAC_W];
    rsp.chan  <= s2_chan;
    rsp.value <= shifted[VAL_W-1:0];
  end

endmodule

>>> tb/sv/power_rail_supervisor_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for power_rail_supervisor_top: scoreboarded checks over register sweeps.
module power_rail_supervisor_top_tb;
  import prs_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 10;
  localparam int NSCAN = SCANS_AVERAGED_DEF;
  localparam int STORE_WORDS = NSCAN * CHANNELS;
  localparam int RAW_MAX = 4095;

  // fixed scale factors: mV or mA = avg * NUM / DEN, truncating
  localparam int unsigned V25_NUM = 67925;
  localparam int unsigned V25_DEN = 9216;
  localparam int unsigned V12_NUM = 3575;
  localparam int unsigned V12_DEN = 1024;
  localparam int unsigned V5_NUM  = 715;
  localparam int unsigned V5_DEN  = 512;
  localparam int unsigned CUR_NUM = 165;
  localparam int unsigned CUR_DEN = 128;

  localparam int DRAIN_CYCLES    = 80;      // settling time after the last check or store
  localparam int HOLD_OFF_CYCLES = 600;     // long enough to back up several checks
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int MAX_REPORTED    = 10;
  localparam int PHASE_WORDS     = 220;

  // index with no register behind it; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic                req_type;
    logic [SAMPLE_W-1:0] sample;
  } adc_word_t;

  typedef struct packed {
    logic [14:0] rail25_mv;
    logic [13:0] rail12_mv;
    logic [12:0] rail5_mv;
    logic [12:0] current5_ma;
    logic [12:0] current12_ma;
    logic        rail12_trip;
    logic        rail5_trip;
  } rail_report_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_SPARSE, RX_COIN, RX_PERIODIC} rx_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  prs_req_if req ();
  prs_res_if res ();
  prs_cfg_if cfg ();

  power_rail_supervisor_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cfg (cfg)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the supervisor: sample ring, limits, over-current run length
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0]   scan_mem [STORE_WORDS];
  int                    write_pos;
  logic [TRIP_W-1:0]     oc_run;
  logic [CFG_DATA_W-1:0] lim_v12_hi, lim_v12_lo, lim_i12;
  logic [CFG_DATA_W-1:0] lim_v5_hi, lim_v5_lo, lim_i5;
  logic [TRIP_W-1:0]     trip_lim;

  adc_word_t    pending_words [$];     // words waiting for the driver
  rail_report_t expected_reports [$];  // one per accepted check, oldest first

  int  queued_slot;      // ring position the next queued store will land on
  int  words_queued;
  int  checks_seen;
  int  trips12_seen;
  int  trips5_seen;
  int  mismatch_count;
  int  cycle_count;
  int  settings_run;
  int  hold_requested;
  int  hold_served;
  int  hold_left;
  int  gap_left;
  int  burst_left;
  int  rx_span;
  rx_mode_e     rx_mode;
  logic         req_taken;
  adc_word_t    word_now;
  rail_report_t want_report;
  rail_report_t seen_report;

  function automatic void record_sample(input logic [SAMPLE_W-1:0] value);
    scan_mem[write_pos] = value;
    write_pos = (write_pos + 1) % STORE_WORDS;
  endfunction

  // Averages every channel over the ring, scales, and decides both trips.
  function automatic rail_report_t predict_rail_check();
    int unsigned  avg [CHANNELS];
    int unsigned  sum, v25, v12, v5, i5, i12;
    rail_report_t r;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      sum = 0;
      for (int s = 0; s < NSCAN; s++) sum += 32'(scan_mem[s * CHANNELS + ch]);
      avg[ch] = sum / NSCAN;
    end
    v25 = avg[CH_V25] * V25_NUM / V25_DEN;
    v12 = avg[CH_V12] * V12_NUM / V12_DEN;
    v5  = avg[CH_V5]  * V5_NUM  / V5_DEN;
    i5  = avg[CH_I5]  * CUR_NUM / CUR_DEN;
    i12 = avg[CH_I12] * CUR_NUM / CUR_DEN;
    r.rail25_mv    = v25[14:0];
    r.rail12_mv    = v12[13:0];
    r.rail5_mv     = v5[12:0];
    r.current5_ma  = i5[12:0];
    r.current12_ma = i12[12:0];
    r.rail12_trip  = (v12 > lim_v12_hi) || (v12 < lim_v12_lo) || (i12 > lim_i12);
    r.rail5_trip   = 1'b0;
    if (v5 > lim_v5_hi || v5 < lim_v5_lo) begin
      // window fault trips at once and restarts the over-current count
      r.rail5_trip = 1'b1;
      oc_run = '0;
    end else if (i5 > lim_i5) begin
      oc_run = oc_run + 1'b1;
      if (oc_run >= trip_lim) begin
        r.rail5_trip = 1'b1;
        oc_run = '0;
      end
    end else begin
      oc_run = '0;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned seen);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED)
      $display("MISMATCH at check %0d, %s: expected %0d, got %0d",
               checks_seen, what, want, seen);
  endtask

  // ---------------------------------------------------------------------------
  // Register writes (only issued while the block is idle)
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_RAIL12_HIGH: lim_v12_hi = val;
      REG_RAIL12_LOW:  lim_v12_lo = val;
      REG_RAIL12_MAX:  lim_i12    = val;
      REG_RAIL5_HIGH:  lim_v5_hi  = val;
      REG_RAIL5_LOW:   lim_v5_lo  = val;
      REG_RAIL5_MAX:   lim_i5     = val;
      REG_TRIP_CHECKS: trip_lim   = val[TRIP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic load_limits(input logic [15:0] h12, input logic [15:0] l12,
                             input logic [15:0] m12, input logic [15:0] h5,
                             input logic [15:0] l5, input logic [15:0] m5,
                             input logic [TRIP_W-1:0] tc);
    logic [15:0] tc_word;
    tc_word = 16'($urandom_range(0, 16'hFFFF));
    tc_word[TRIP_W-1:0] = tc;   // junk above the 4-bit field must be dropped
    write_reg(REG_RAIL12_HIGH, h12);
    write_reg(REG_RAIL12_LOW, l12);
    write_reg(REG_RAIL12_MAX, m12);
    write_reg(REG_RAIL5_HIGH, h5);
    write_reg(REG_RAIL5_LOW, l5);
    write_reg(REG_RAIL5_MAX, m5);
    write_reg(REG_TRIP_CHECKS, tc_word);
    settings_run++;
  endtask

  // Wait until every word went in and every result came out, then let the pipe settle.
  task automatic drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || req.valid || expected_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  function automatic void push_word(input logic kind, input logic [SAMPLE_W-1:0] value);
    adc_word_t w;
    w.req_type = kind;
    w.sample   = value;
    pending_words.push_back(w);
    words_queued++;
    if (kind == REQ_STORE) queued_slot = (queued_slot + 1) % STORE_WORDS;
  endfunction

  // Raw level for one channel: extremes, anything, or close to a default threshold.
  // Raw marks: 12 V window 3171..3875 (nominal 3437), 5 V low edge 3437,
  // 5 V current limit about 776, 12 V current limit about 2715.
  function automatic int pick_level(input int ch);
    int r, k, near;
    r = $urandom_range(0, 7);
    k = $urandom_range(0, 2);
    if (r == 0) return 0;
    if (r == 1) return RAW_MAX;
    if (r <= 3) return $urandom_range(0, RAW_MAX);
    case (ch)
      CH_V12:  near = (k == 0) ? 3171 : (k == 1) ? 3437 : 3875;
      CH_V5:   near = (k == 0) ? 3437 : (k == 1) ? 3580 : 4000;
      CH_I5:   near = (k == 0) ? 776 : (k == 1) ? 1100 : 400;
      CH_I12:  near = (k == 0) ? 2715 : (k == 1) ? 3200 : 1500;
      default: near = 3392;
    endcase
    return near + int'($urandom_range(0, 120)) - 60;
  endfunction

  task automatic queue_scan(input int level [CHANNELS], input int jitter);
    int v;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      v = level[ch] + int'($urandom_range(0, 2 * jitter)) - jitter;
      if (v < 0) v = 0;
      if (v > RAW_MAX) v = RAW_MAX;
      push_word(REQ_STORE, SAMPLE_W'(v));
    end
  endtask

  // Mostly aligned scans around the thresholds with checks sprinkled in;
  // the rest is loose noise and partial scans.
  task automatic queue_random_words(input int n);
    int target, kind, scans, chk_pct, jitter;
    int level [CHANNELS];
    target = words_queued + n;
    while (words_queued < target) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 8))
          push_word(1'($urandom_range(0, 1)), SAMPLE_W'($urandom_range(0, RAW_MAX)));
      end else if (kind == 1) begin
        repeat ($urandom_range(1, CHANNELS - 1))
          push_word(REQ_STORE, SAMPLE_W'($urandom_range(0, RAW_MAX)));
        push_word(REQ_CHECK, SAMPLE_W'($urandom_range(0, RAW_MAX)));
      end else begin
        // realign to a scan boundary so channels land where they belong
        while (queued_slot % CHANNELS != 0)
          push_word(REQ_STORE, SAMPLE_W'($urandom_range(0, RAW_MAX)));
        for (int ch = 0; ch < CHANNELS; ch++) level[ch] = pick_level(ch);
        jitter  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
        k_pct: begin
          case ($urandom_range(0, 2))
            0:       chk_pct = 25;
            1:       chk_pct = 60;
            default: chk_pct = 100;
          endcase
        end
        scans = $urandom_range(1, 2 * NSCAN);
        repeat (scans) begin
          queue_scan(level, jitter);
          if ($urandom_range(1, 100) <= chk_pct)
            push_word(REQ_CHECK, SAMPLE_W'($urandom_range(0, RAW_MAX)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps; holds a word until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        req.valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        word_now = pending_words.pop_front();
        req.valid    <= 1'b1;
        req.req_type <= word_now.req_type;
        req.sample   <= word_now.sample;
        if (burst_left > 1) begin
          burst_left--;
        end else if ($urandom_range(0, 4) == 0) begin
          burst_left = 200;   // long stretch with no idling
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = $urandom_range(0, 20);
        end
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Acceptance: a word is taken when valid and ready meet at the edge.
  always @(posedge clk) begin
    req_taken = req.valid && req.ready;
    if (!rst && req_taken) begin
      if (req.req_type == REQ_CHECK) expected_reports.push_back(predict_rail_check());
      else record_sample(req.sample);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: rotating stall patterns, plus long hold-offs on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_left != 0 || hold_served != hold_requested) begin
      if (hold_left == 0) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_served++;
      end else begin
        hold_left--;
      end
      res.ready <= 1'b0;
    end else begin
      if (rx_span == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_span = $urandom_range(50, 300);
      end else begin
        rx_span--;
      end
      case (rx_mode)
        RX_ALWAYS: res.ready <= 1'b1;
        RX_SPARSE: res.ready <= ($urandom_range(0, 3) == 0);
        RX_COIN:   res.ready <= 1'($urandom_range(0, 1));
        default:   res.ready <= ((cycle_count % 7) >= 3);
      endcase
    end
  end

  // Monitor: compare each result word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      seen_report = {res.rail25_mv, res.rail12_mv, res.rail5_mv, res.current5_ma,
                     res.current12_ma, res.rail12_trip, res.rail5_trip};
      if (expected_reports.size() == 0) begin
        flag_mismatch("result with no check pending", 0, 32'(seen_report.rail12_mv));
      end else begin
        want_report = expected_reports.pop_front();
        checks_seen++;
        trips12_seen += int'(want_report.rail12_trip);
        trips5_seen  += int'(want_report.rail5_trip);
        if (seen_report.rail25_mv != want_report.rail25_mv)
          flag_mismatch("rail25_mv", 32'(want_report.rail25_mv),
                        32'(seen_report.rail25_mv));
        if (seen_report.rail12_mv != want_report.rail12_mv)
          flag_mismatch("rail12_mv", 32'(want_report.rail12_mv),
                        32'(seen_report.rail12_mv));
        if (seen_report.rail5_mv != want_report.rail5_mv)
          flag_mismatch("rail5_mv", 32'(want_report.rail5_mv),
                        32'(seen_report.rail5_mv));
        if (seen_report.current5_ma != want_report.current5_ma)
          flag_mismatch("current5_ma", 32'(want_report.current5_ma),
                        32'(seen_report.current5_ma));
        if (seen_report.current12_ma != want_report.current12_ma)
          flag_mismatch("current12_ma", 32'(want_report.current12_ma),
                        32'(seen_report.current12_ma));
        if (seen_report.rail12_trip != want_report.rail12_trip)
          flag_mismatch("rail12_trip", 32'(want_report.rail12_trip),
                        32'(seen_report.rail12_trip));
        if (seen_report.rail5_trip != want_report.rail5_trip)
          flag_mismatch("rail5_trip", 32'(want_report.rail5_trip),
                        32'(seen_report.rail5_trip));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_reports.size());
      $display("power_rail_supervisor_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    req.valid    = 1'b0;
    req.req_type = REQ_STORE;
    req.sample   = '0;
    res.ready    = 1'b0;
    cfg.valid    = 1'b0;
    cfg.index    = REG_RAIL12_HIGH;
    cfg.data     = '0;

    // shadow starts from the reset state
    foreach (scan_mem[i]) scan_mem[i] = '0;
    write_pos      = 0;
    oc_run         = '0;
    lim_v12_hi     = RST_RAIL12_HIGH;
    lim_v12_lo     = RST_RAIL12_LOW;
    lim_i12        = RST_RAIL12_MAX;
    lim_v5_hi      = RST_RAIL5_HIGH;
    lim_v5_lo      = RST_RAIL5_LOW;
    lim_i5         = RST_RAIL5_MAX;
    trip_lim       = RST_TRIP_CHECKS;
    queued_slot    = 0;
    words_queued   = 0;
    checks_seen    = 0;
    trips12_seen   = 0;
    trips5_seen    = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    settings_run   = 1;
    hold_requested = 0;
    hold_served    = 0;
    hold_left      = 0;
    gap_left       = 0;
    burst_left     = 1;
    rx_span        = 0;
    rx_mode        = RX_ALWAYS;
    req_taken      = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, at reset limits: empty store, all-ones scan, alternating bits,
    // zero scan, then a lone store that leaves the ring off a scan boundary.
    push_word(REQ_CHECK, '0);
    repeat (CHANNELS) push_word(REQ_STORE, SAMPLE_W'(RAW_MAX));
    push_word(REQ_CHECK, SAMPLE_W'(RAW_MAX));
    push_word(REQ_STORE, 12'hAAA);
    push_word(REQ_STORE, 12'h555);
    push_word(REQ_STORE, 12'hAAA);
    push_word(REQ_STORE, 12'h555);
    push_word(REQ_STORE, 12'hAAA);
    push_word(REQ_CHECK, 12'h555);
    repeat (CHANNELS) push_word(REQ_STORE, '0);
    push_word(REQ_CHECK, '0);
    push_word(REQ_STORE, 12'd1);
    push_word(REQ_CHECK, '0);
    queue_random_words(200);
    drain();

    // windows wide open, current limits out of reach, longest trip count
    load_limits(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 4'd15);
    queue_random_words(PHASE_WORDS);
    drain();

    // windows inverted, zero current limits, single-check trip;
    // receiver backs off for a long stretch while words keep coming
    load_limits(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 4'd1);
    queue_random_words(PHASE_WORDS);
    hold_requested++;
    drain();

    // reset limits with a zero trip count: any 5 V over-current trips at once;
    // a write to the unmapped index must leave everything alone
    load_limits(RST_RAIL12_HIGH, RST_RAIL12_LOW, RST_RAIL12_MAX, RST_RAIL5_HIGH,
                RST_RAIL5_LOW, RST_RAIL5_MAX, 4'd0);
    write_reg(REG_UNMAPPED, 16'($urandom_range(0, 16'hFFFF)));
    queue_random_words(PHASE_WORDS);
    drain();

    // limits scattered around nominal, last pass fully random
    for (int p = 0; p < 4; p++) begin
      if (p == 3)
        load_limits(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                    16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                    16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                    TRIP_W'($urandom_range(0, 15)));
      else
        load_limits(16'(12000 + $urandom_range(0, 2500)), 16'(12000 - $urandom_range(0, 1500)),
                    16'($urandom_range(0, 5300)), 16'(5000 + $urandom_range(0, 800)),
                    16'(5000 - $urandom_range(0, 600)), 16'($urandom_range(300, 1800)),
                    TRIP_W'($urandom_range(1, 15)));
      queue_random_words(PHASE_WORDS);
      if (p == 1) hold_requested++;
      drain();
    end

    $display("Ran %0d request words through %0d register settings; %0d checks compared.",
             words_queued, settings_run, checks_seen);
    $display("Expected trips: 12 V %0d, 5 V %0d; receiver hold-offs %0d; mismatches %0d.",
             trips12_seen, trips5_seen, hold_served, mismatch_count);
    if (mismatch_count == 0 && expected_reports.size() == 0)
      $display("power_rail_supervisor_top regression: pass");
    else
      $display("power_rail_supervisor_top regression: fail");
    $finish;
  end

endmodule
